FILE: rtl/three_address_code_executor_macros.svh
// Assertion macros for the three-address code executor.
// Included by the top level; depends on nothing else.
`ifndef THREE_ADDRESS_CODE_EXECUTOR_MACROS_SVH
`define THREE_ADDRESS_CODE_EXECUTOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TACE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tace: same-cycle implication violated");

// Next-cycle implication, disabled during reset
`define TACE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tace: next-cycle implication violated");

`endif

FILE: rtl/tace_pkg.sv
// Shared types and codes for the three-address code executor.
// No dependencies; imported by the top level and the testbench.
package tace_pkg;

  // Instruction opcodes
  typedef enum logic [2:0] {
    OP_PRINT  = 3'd0,
    OP_READ   = 3'd1,
    OP_BRANCH = 3'd2,
    OP_ARITH  = 3'd3,
    OP_MOVE   = 3'd4
  } opcode_t;

  // Arithmetic function codes (anything above FN_DIV also divides)
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd1;
  localparam logic [2:0] FN_MUL = 3'd2;
  localparam logic [2:0] FN_DIV = 3'd3;

  // Branch relation codes
  localparam logic [2:0] CMP_LT = 3'd0;
  localparam logic [2:0] CMP_LE = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_GE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_FETCH,
    ST_EXEC,
    ST_SERIAL,
    ST_SIGN,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/three_address_code_executor.sv
// Three-address code executor: one instruction per transaction against a variable memory.
// Steps: capture (IDLE), index reduction (REDUCE), operand read (FETCH), execute (EXEC),
// then, for multiply and for divide by a nonzero divisor, a serial loop (SERIAL) and sign fix
// (SIGN), and last write-back (DONE). A new instruction is taken only in IDLE, after the previous
// result has entered the output register; the serial loop is a one-bit-per-cycle shift-add /
// restoring divide over the operand width. Reset (rst, synchronous): pc to zero, then a clearing
// pass writes the most negative value into every variable; no instruction is taken until it ends.
`include "three_address_code_executor_macros.svh"

module three_address_code_executor #(
  parameter int NUM_VARS   = 256,
  parameter int DATA_WIDTH = 32,
  parameter int PC_WIDTH   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_index[7:0], a_operand[39:8], b_operand[71:40], func[74:72],
  // branch_target[90:75], read_value[122:91], zero fill [127:123]
  input  logic [127:0] s_axis_tdata,
  // opcode[2:0], a_is_literal[3], b_is_literal[4]
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // print_value[31:0], next_pc[47:32]
  output logic [47:0]  m_axis_tdata,
  // print_valid[0], branch_taken[1], div_by_zero[2]
  output logic [2:0]   m_axis_tuser
);
  import tace_pkg::*;

  localparam int SLOT_W = $clog2(NUM_VARS);
  localparam int CNT_W  = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  // floor(2^32 / NUM_VARS) for the index reduction
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_VARS);
  localparam logic [31:0] NV32  = 32'(NUM_VARS);
  localparam logic [SLOT_W:0] NV_REM = (SLOT_W+1)'(NUM_VARS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_VARS - 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  // Input field views
  logic [7:0]  in_dest;
  logic [31:0] in_a, in_b, in_rv;
  logic [2:0]  in_func;
  logic [15:0] in_bt;
  assign in_dest = s_axis_tdata[7:0];
  assign in_a    = s_axis_tdata[39:8];
  assign in_b    = s_axis_tdata[71:40];
  assign in_func = s_axis_tdata[74:72];
  assign in_bt   = s_axis_tdata[90:75];
  assign in_rv   = s_axis_tdata[122:91];

  state_t state, state_next;

  // Captured instruction
  opcode_t     op_q;
  logic [2:0]  func_q;
  logic        a_lit_q, b_lit_q;
  logic [31:0] a_op_q, b_op_q, d_op_q, rv_q;
  logic [15:0] bt_q;

  // Index reduction pipeline
  logic [31:0]     qa, qb, qd;
  logic [63:0]     prod_a, prod_b, prod_d, qn_a, qn_b, qn_d;
  logic [SLOT_W:0] rem_a, rem_b, rem_d;
  logic [SLOT_W-1:0] slot_a, slot_b, slot_d_fix, slot_d;

  // Variable memory
  logic [DATA_WIDTH-1:0] mem [NUM_VARS];
  logic [DATA_WIDTH-1:0] rd_a, rd_b;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [SLOT_W-1:0]     clr_idx;

  // Execute operands
  logic signed [DATA_WIDTH-1:0] op_a, op_b;
  logic [DATA_WIDTH-1:0]        mag_a, mag_b;
  logic                         lt, eq, cond, needs_serial, b_zero;

  // Serial multiply / divide unit
  logic [DATA_WIDTH-1:0] acc, work, opnd;
  logic [CNT_W-1:0]      cnt;
  logic                  is_div, q_neg;
  logic [DATA_WIDTH:0]   rem_sh, rem_diff;
  logic                  rem_ge;

  // Result registers
  logic [DATA_WIDTH-1:0] res_value;
  logic                  res_write, res_print_valid, res_taken, res_dz;
  logic [31:0]           res_print_value;
  logic [PC_WIDTH-1:0]   res_pc, pc;

  // Result of the instruction in execute
  logic [DATA_WIDTH-1:0] res_value_next;
  logic                  res_write_next, res_print_valid_next, res_taken_next, res_dz_next;
  logic [31:0]           res_print_value_next;
  logic [PC_WIDTH-1:0]   res_pc_next;

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // Reciprocal products and remainders
  assign prod_a = {32'd0, in_a} * {32'd0, RECIP};
  assign prod_b = {32'd0, in_b} * {32'd0, RECIP};
  assign prod_d = {24'd0, in_dest, 32'd0} >> 32 == 64'd0 ? 64'd0 :
                  {32'd0, 24'd0, in_dest} * {32'd0, RECIP};
  assign qn_a = {32'd0, qa} * {32'd0, NV32};
  assign qn_b = {32'd0, qb} * {32'd0, NV32};
  assign qn_d = {32'd0, qd} * {32'd0, NV32};

  // Final correction: remainder is below twice the depth
  assign slot_a     = (rem_a >= NV_REM) ? SLOT_W'(rem_a - NV_REM) : SLOT_W'(rem_a);
  assign slot_b     = (rem_b >= NV_REM) ? SLOT_W'(rem_b - NV_REM) : SLOT_W'(rem_b);
  assign slot_d_fix = (rem_d >= NV_REM) ? SLOT_W'(rem_d - NV_REM) : SLOT_W'(rem_d);

  // Operand selection and compare
  assign op_a   = a_lit_q ? DATA_WIDTH'(signed'(a_op_q)) : signed'(rd_a);
  assign op_b   = b_lit_q ? DATA_WIDTH'(signed'(b_op_q)) : signed'(rd_b);
  assign mag_a  = op_a[DATA_WIDTH-1] ? DATA_WIDTH'(-op_a) : op_a;
  assign mag_b  = op_b[DATA_WIDTH-1] ? DATA_WIDTH'(-op_b) : op_b;
  assign lt     = op_a < op_b;
  assign eq     = op_a == op_b;
  assign b_zero = (op_b == '0);
  assign needs_serial = (op_q == OP_ARITH) && (func_q != FN_ADD) && (func_q != FN_SUB) &&
                        ((func_q == FN_MUL) || !b_zero);

  always_comb begin
    case (func_q)
      CMP_LT:  cond = lt;
      CMP_LE:  cond = lt || eq;
      CMP_GT:  cond = !lt && !eq;
      CMP_GE:  cond = !lt;
      CMP_EQ:  cond = eq;
      CMP_NE:  cond = !eq;
      default: cond = 1'b0;
    endcase
  end

  // Decode the result fields of the instruction in execute
  always_comb begin
    res_write_next       = 1'b0;
    res_print_valid_next = 1'b0;
    res_print_value_next = '0;
    res_taken_next       = 1'b0;
    res_dz_next          = 1'b0;
    res_pc_next          = pc + 1'b1;
    res_value_next       = op_a;
    unique case (op_q)
      OP_PRINT: begin
        res_print_valid_next = 1'b1;
        res_print_value_next = 32'(op_a);
      end
      OP_READ: begin
        res_write_next = 1'b1;
        res_value_next = DATA_WIDTH'(signed'(rv_q));
      end
      OP_BRANCH: begin
        if (cond) begin
          res_taken_next = 1'b1;
          res_pc_next    = PC_WIDTH'(bt_q);
        end
      end
      OP_ARITH: begin
        res_write_next = 1'b1;
        case (func_q)
          FN_ADD: res_value_next = op_a + op_b;
          FN_SUB: res_value_next = op_a - op_b;
          // product comes from the serial loop
          FN_MUL: ;
          default: begin
            if (b_zero) begin
              res_value_next = '0;
              res_dz_next    = 1'b1;
            end
          end
        endcase
      end
      OP_MOVE: res_write_next = 1'b1;
      default: ;
    endcase
  end

  // Restoring divide step
  assign rem_sh   = {acc, work[DATA_WIDTH-1]};
  assign rem_ge   = rem_sh >= {1'b0, opnd};
  assign rem_diff = rem_sh - {1'b0, opnd};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_idx == LAST_SLOT) state_next = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_REDUCE;
      ST_REDUCE: state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_EXEC;
      ST_EXEC:   state_next = needs_serial ? ST_SERIAL : ST_DONE;
      ST_SERIAL: if (cnt == LAST_STEP) state_next = ST_SIGN;
      ST_SIGN:   state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory write port: clearing pass or instruction write-back
  assign mem_we    = (state == ST_CLEAR) || ((state == ST_DONE) && out_free && res_write);
  assign mem_waddr = (state == ST_CLEAR) ? clr_idx : slot_d;
  assign mem_wdata = (state == ST_CLEAR) ? INT_MIN : res_value;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // Registered reads of both operands
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      rd_a <= mem[slot_a];
      rd_b <= mem[slot_b];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      pc            <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if ((state == ST_DONE) && out_free) begin
        pc            <= res_pc;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // capture the transaction and start the index reduction
        op_q    <= opcode_t'(s_axis_tuser[2:0]);
        a_lit_q <= s_axis_tuser[3];
        b_lit_q <= s_axis_tuser[4];
        a_op_q  <= in_a;
        b_op_q  <= in_b;
        d_op_q  <= {24'd0, in_dest};
        func_q  <= in_func;
        bt_q    <= in_bt;
        rv_q    <= in_rv;
        qa      <= prod_a[63:32];
        qb      <= prod_b[63:32];
        qd      <= prod_d[63:32];
      end
      ST_REDUCE: begin
        rem_a <= a_op_q[SLOT_W:0] - qn_a[SLOT_W:0];
        rem_b <= b_op_q[SLOT_W:0] - qn_b[SLOT_W:0];
        rem_d <= d_op_q[SLOT_W:0] - qn_d[SLOT_W:0];
      end
      ST_FETCH: slot_d <= slot_d_fix;
      ST_EXEC: begin
        res_write       <= res_write_next;
        res_print_valid <= res_print_valid_next;
        res_print_value <= res_print_value_next;
        res_taken       <= res_taken_next;
        res_dz          <= res_dz_next;
        res_pc          <= res_pc_next;
        res_value       <= res_value_next;
        cnt             <= '0;
        // load the serial unit: shift-add keeps the multiplier in work and the
        // multiplicand in opnd; divide runs on magnitudes, sign fixed afterwards
        is_div <= (func_q != FN_MUL);
        q_neg  <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
        acc    <= '0;
        work   <= (func_q == FN_MUL) ? op_b : mag_a;
        opnd   <= (func_q == FN_MUL) ? op_a : mag_b;
      end
      ST_SERIAL: begin
        cnt <= cnt + 1'b1;
        if (is_div) begin
          work <= {work[DATA_WIDTH-2:0], rem_ge};
          acc  <= rem_ge ? rem_diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
        end else begin
          if (work[0]) acc <= acc + opnd;
          opnd <= opnd << 1;
          work <= work >> 1;
        end
      end
      ST_SIGN: res_value <= is_div ? (q_neg ? DATA_WIDTH'(-work) : work) : acc;
      ST_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {16'(res_pc), res_print_value};
          m_axis_tuser <= {res_dz, res_taken, res_print_valid};
        end
      end
      default: ;
    endcase
  end

  // No result leaves before the clearing pass has finished
  `TACE_ASSERT_IMP(a_no_result_in_clear, clk, rst, state == ST_CLEAR, !m_axis_tvalid)
  // A new result appears only from write-back
  `TACE_ASSERT_IMP(a_result_from_done, clk, rst, $rose(m_axis_tvalid), $past(state) == ST_DONE)
  // Write-back with a free output slot always presents a result
  `TACE_ASSERT_NXT(a_done_presents, clk, rst, (state == ST_DONE) && out_free, m_axis_tvalid)
  // The serial loop moves on to the sign fix once its step count reaches the last step
  `TACE_ASSERT_NXT(a_serial_ends, clk, rst, (state == ST_SERIAL) && (cnt == LAST_STEP),
                   state == ST_SIGN)

endmodule

FILE: test/tb_three_address_code_executor.sv
// Self-checking testbench for the three-address code executor.
// Depends on tace_pkg and the three_address_code_executor top level.
`timescale 1ns / 100ps

module tb_three_address_code_executor;
  import tace_pkg::*;

  // Opcodes and relation codes outside the defined sets, and an upper function code that divides
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [2:0] CMP_RSVD_LO  = 3'd6;
  localparam logic [2:0] CMP_RSVD_HI  = 3'd7;
  localparam logic [2:0] FN_DIV_ALT   = 3'd4;

  localparam int N_RANDOM    = 1600;
  localparam int HOLD_LEN    = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  dest;
    logic        a_lit;
    logic [31:0] a_op;
    logic        b_lit;
    logic [31:0] b_op;
    logic [2:0]  func;
    logic [15:0] target;
    logic [31:0] rd_val;
  } instr_t;

  typedef struct packed {
    logic        print_valid;
    logic [31:0] print_value;
    logic        taken;
    logic [15:0] next_pc;
    logic        div_zero;
  } result_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // dest_index, a_operand, b_operand, func, branch_target, read_value, zero fill
  logic [127:0] s_axis_tdata = '0;
  // opcode, a_is_literal, b_is_literal
  logic [4:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // print_value, next_pc
  logic [47:0]  m_axis_tdata;
  // print_valid, branch_taken, div_by_zero
  logic [2:0]   m_axis_tuser;

  instr_t  instr_queue[$];
  result_t expected_results[$];
  instr_t  cur_instr;
  result_t want, got;

  logic signed [31:0] vars_shadow [256];
  logic [15:0]        pc_shadow;

  int n_total;
  int n_accepted = 0;
  int mismatches = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int quiet      = 0;
  int hold_at, drain_at;

  three_address_code_executor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Execute one instruction on the shadow state and return its result
  function automatic result_t execute_instr(instr_t in);
    logic signed [31:0] a, b, r;
    logic               lt, eq, cond;
    longint             q;
    result_t            res;
    res = '0;
    res.next_pc = pc_shadow + 16'd1;
    a = in.a_lit ? $signed(in.a_op) : vars_shadow[in.a_op[7:0]];
    b = in.b_lit ? $signed(in.b_op) : vars_shadow[in.b_op[7:0]];
    case (in.opcode)
      OP_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = a;
      end
      OP_READ: vars_shadow[in.dest] = in.rd_val;
      OP_BRANCH: begin
        lt = (a < b);
        eq = (a == b);
        case (in.func)
          CMP_LT:  cond = lt;
          CMP_LE:  cond = lt || eq;
          CMP_GT:  cond = !lt && !eq;
          CMP_GE:  cond = !lt;
          CMP_EQ:  cond = eq;
          CMP_NE:  cond = !eq;
          default: cond = 1'b0;
        endcase
        if (cond) begin
          res.taken   = 1'b1;
          res.next_pc = in.target;
        end
      end
      OP_ARITH: begin
        case (in.func)
          FN_ADD: r = a + b;
          FN_SUB: r = a - b;
          FN_MUL: r = a * b;
          default: begin
            // any other code divides; zero divisor writes zero and flags
            if (b == 0) begin
              r = '0;
              res.div_zero = 1'b1;
            end else begin
              q = longint'(a) / longint'(b);
              r = q[31:0];
            end
          end
        endcase
        vars_shadow[in.dest] = r;
      end
      OP_MOVE: vars_shadow[in.dest] = a;
      default: ;
    endcase
    pc_shadow = res.next_pc;
    return res;
  endfunction

  function automatic instr_t mk(logic [2:0] op, logic [7:0] dest, logic a_lit,
                                logic [31:0] a_op, logic b_lit, logic [31:0] b_op,
                                logic [2:0] func, logic [15:0] target,
                                logic [31:0] rd_val);
    instr_t t;
    t = '{op, dest, a_lit, a_op, b_lit, b_op, func, target, rd_val};
    return t;
  endfunction

  // Append an instruction to the pending stream
  function automatic void queue_instr(instr_t t);
    instr_queue.insert(instr_queue.size(), t);
  endfunction

  // Values biased toward the extremes and small magnitudes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(0, 16)) - 32'd8;
      3:       return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  // Variable index with random upper bits, mostly hitting a small working set
  function automatic logic [31:0] rand_index();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 9) < 7) w[7:0] = 8'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic instr_t rand_instr();
    instr_t t;
    if ($urandom_range(0, 99) < 3)
      t.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    else
      t.opcode = 3'($urandom_range(OP_PRINT, OP_MOVE));
    t.dest   = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom());
    t.a_lit  = 1'($urandom_range(0, 1));
    t.a_op   = t.a_lit ? rand_word() : rand_index();
    t.b_lit  = 1'($urandom_range(0, 1));
    t.b_op   = t.b_lit ? rand_word() : rand_index();
    if ($urandom_range(0, 99) < 5)
      t.func = 3'($urandom_range(CMP_RSVD_LO, CMP_RSVD_HI));
    else
      t.func = 3'($urandom_range(CMP_LT, CMP_NE));
    t.target = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom());
    t.rd_val = rand_word();
    return t;
  endfunction

  function automatic int idle_pct(bit sender);
    case (n_accepted * 3 / n_total)
      0:       return sender ? 29 : 79;
      1:       return sender ? 79 : 29;
      default: return 0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %h, actual %h", name, exp_v, act_v);
    end
  endfunction

  // Build the instruction stream, release reset, wait for the drain
  initial begin
    for (int i = 0; i < 256; i++) vars_shadow[i] = 32'sh8000_0000;
    pc_shadow = '0;

    // print literal extremes and a reset-state variable via an out-of-range index
    queue_instr(mk(OP_PRINT, 8'd0, 1'b1, 32'h7FFF_FFFF, 1'b0, 0, FN_ADD, 0, 0));
    queue_instr(mk(OP_PRINT, 8'd0, 1'b1, 32'h8000_0000, 1'b0, 0, FN_ADD, 0, 0));
    queue_instr(mk(OP_PRINT, 8'd0, 1'b0, 32'hFFFF_FF05, 1'b0, 0, FN_ADD, 0, 0));
    // read in extremes at both ends of the store
    queue_instr(mk(OP_READ, 8'd0, 1'b0, 0, 1'b0, 0, FN_ADD, 0, 32'h7FFF_FFFF));
    queue_instr(mk(OP_READ, 8'hFF, 1'b0, 0, 1'b0, 0, FN_ADD, 0, 32'h8000_0000));
    // move a character code, then a variable
    queue_instr(mk(OP_MOVE, 8'd1, 1'b1, 32'd65, 1'b0, 0, FN_ADD, 0, 0));
    queue_instr(mk(OP_MOVE, 8'd2, 1'b0, 32'd0, 1'b0, 0, FN_ADD, 0, 0));
    // wrapping add, sub and mul
    queue_instr(mk(OP_ARITH, 8'd3, 1'b0, 32'd0, 1'b1, 32'd1, FN_ADD, 0, 0));
    queue_instr(mk(OP_ARITH, 8'd4, 1'b1, 32'h8000_0000, 1'b1, 32'd1, FN_SUB, 0, 0));
    queue_instr(mk(OP_ARITH, 8'd5, 1'b0, 32'd0, 1'b0, 32'd0, FN_MUL, 0, 0));
    // truncating division in both signs, zero divisor, most negative over minus one
    queue_instr(mk(OP_ARITH, 8'd6, 1'b1, 32'd7, 1'b1, -32'sd2, FN_DIV, 0, 0));
    queue_instr(mk(OP_ARITH, 8'd9, 1'b1, -32'sd7, 1'b1, 32'd2, FN_DIV, 0, 0));
    queue_instr(mk(OP_ARITH, 8'd7, 1'b1, 32'd5, 1'b1, 32'd0, FN_DIV, 0, 0));
    queue_instr(mk(OP_ARITH, 8'd8, 1'b1, 32'h8000_0000, 1'b1, -32'sd1, FN_DIV,
                   0, 0));
    // upper function codes divide; divisor taken from a zeroed variable
    queue_instr(mk(OP_ARITH, 8'd10, 1'b1, 32'd100, 1'b0, 32'd7, FN_DIV_ALT, 0, 0));
    queue_instr(mk(OP_ARITH, 8'd11, 1'b1, -32'sd100, 1'b1, 32'd7, CMP_RSVD_HI,
                   0, 0));
    // every relation
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b1, -32'sd1, 1'b1, 32'd0, CMP_LT, 16'h0000, 0));
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b0, 32'd3, 1'b1, 32'h8000_0000, CMP_LE,
                   16'd1234, 0));
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b1, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000,
                   CMP_GT, 16'hAAAA, 0));
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b1, -32'sd5, 1'b1, 32'd3, CMP_GE, 16'h5555, 0));
    // taken to the top pc, so the next instruction wraps it
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b0, 32'd1, 1'b1, 32'd65, CMP_EQ, 16'hFFFF, 0));
    queue_instr(mk(OP_PRINT, 8'd0, 1'b0, 32'd6, 1'b0, 0, FN_ADD, 0, 0));
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b0, 32'd2, 1'b0, 32'd0, CMP_NE, 16'h0F0F, 0));
    // reserved relations never branch
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b1, 0, 1'b1, 0, CMP_RSVD_LO, 16'h1111, 0));
    queue_instr(mk(OP_BRANCH, 8'd0, 1'b1, 0, 1'b1, 0, CMP_RSVD_HI, 16'h2222, 0));
    // unused opcodes only advance the pc
    queue_instr(mk(OP_UNUSED_LO, 8'd12, 1'b1, 32'd9, 1'b1, 32'd9, FN_ADD,
                   16'h3333, 32'd9));
    queue_instr(mk(OP_UNUSED_HI, 8'd12, 1'b1, 32'd9, 1'b1, 32'd9, CMP_EQ,
                   16'h3333, 32'd9));
    queue_instr(mk(OP_PRINT, 8'd0, 1'b0, 32'd8, 1'b0, 0, FN_ADD, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) queue_instr(rand_instr());

    n_total  = instr_queue.size();
    drain_at = n_total / 2;
    hold_at  = n_total * 5 / 6;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (!(n_accepted == n_total && expected_results.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Driver: predict on acceptance, then offer the next instruction or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.insert(expected_results.size(), execute_instr(cur_instr));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        // hold off once mid-run until every pending result has arrived
        if (instr_queue.size() > 0
            && !(n_accepted == drain_at && expected_results.size() != 0)
            && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          cur_instr = instr_queue.pop_front();
          s_axis_tdata  <= {5'd0, cur_instr.rd_val, cur_instr.target, cur_instr.func,
                            cur_instr.b_op, cur_instr.a_op, cur_instr.dest};
          s_axis_tuser  <= {cur_instr.b_lit, cur_instr.a_lit, cur_instr.opcode};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result-side backpressure, with one long hold-off late in the run
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_accepted >= hold_at) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tuser[1], m_axis_tdata[47:32],
              m_axis_tuser[2]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction: %h", got);
      end else begin
        want = expected_results.pop_front();
        check_field("print_valid", 32'(want.print_valid), 32'(got.print_valid));
        check_field("print_value", want.print_value, got.print_value);
        check_field("branch_taken", 32'(want.taken), 32'(got.taken));
        check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
        check_field("div_by_zero", 32'(want.div_zero), 32'(got.div_zero));
      end
    end
  end

  // Watchdog: abort after too many cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tace_pkg.sv
rtl/three_address_code_executor.sv
test/tb_three_address_code_executor.sv
